// ===== hw/rtl/dmxr_pkg.sv =====
// shared types and constants for the dmx frame receiver
package dmxr_pkg;

	localparam int MAX_CHANNELS = 512;
	localparam int STORE_DEPTH  = MAX_CHANNELS + 1;
	localparam int STORE_AW     = $clog2(STORE_DEPTH);
	localparam int SLOT_W       = 10;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;

	localparam logic [15:0]     BREAK_GAP_RESET  = 16'd150;
	localparam logic [7:0]      START_CODE_RESET = 8'd0;
	localparam logic [SLOT_W-1:0] MIN_LEN_RESET  = SLOT_W'(3);

	typedef enum logic [1:0] {
		OP_BYTE     = 2'd0,
		OP_RX_ERROR = 2'd1,
		OP_READ     = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BREAK_GAP  = 2'd0,
		REG_START_CODE = 2'd1,
		REG_MIN_LEN    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  byte_value;
		logic [31:0] time_us;
		logic [9:0]  read_channel;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        frame_done;
		logic [9:0]  frame_length;
		logic [31:0] frames_total;
		logic [31:0] errors_total;
		logic        data_ok;
		logic        in_frame;
	} out_word_t;

	typedef struct packed {
		logic        rd_en;
		logic        frame_done;
		logic [9:0]  frame_length;
		logic [31:0] frames_total;
		logic [31:0] errors_total;
		logic        data_ok;
		logic        in_frame;
	} status_t;

	typedef struct packed {
		logic                we;
		logic [STORE_AW-1:0] waddr;
		logic [7:0]          wdata;
		logic                re;
		logic [STORE_AW-1:0] raddr;
	} store_req_t;

endpackage

// ===== hw/rtl/dmxr_store.sv =====
// channel store: single write port, registered read port
module dmxr_store (
	input  logic                clk,
	input  dmxr_pkg::store_req_t req,
	output logic [7:0]          rdata
);
	import dmxr_pkg::*;

	logic [7:0] mem [STORE_DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/dmxr_ctrl.sv =====
// frame tracking, counters, configuration registers and store access
module dmxr_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [dmxr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmxr_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         accept,
	input  dmxr_pkg::in_word_t           item,
	output dmxr_pkg::status_t            status,
	output dmxr_pkg::store_req_t         store_req
);
	import dmxr_pkg::*;

	logic [15:0]       break_gap_q;
	logic [7:0]        start_code_q;
	logic [SLOT_W-1:0] min_len_q;

	logic              receiving_q;
	logic [SLOT_W-1:0] slot_q;
	logic [31:0]       last_time_q;
	logic [SLOT_W-1:0] comp_len_q;
	logic              valid_q;
	logic [31:0]       frames_q;
	logic [31:0]       errors_q;

	logic              receiving_d;
	logic [SLOT_W-1:0] slot_d;
	logic [31:0]       last_time_d;
	logic [SLOT_W-1:0] comp_len_d;
	logic              valid_d;
	logic [31:0]       frames_d;
	logic [31:0]       errors_d;
	logic              done_d;
	logic              rd_ok;
	logic              we_d;
	logic [STORE_AW-1:0] waddr_d;
	logic [31:0]       gap;
	logic              brk;

	assign gap = item.time_us - last_time_q;
	assign brk = gap > {16'd0, break_gap_q};

	always_comb begin
		receiving_d = receiving_q;
		slot_d      = slot_q;
		last_time_d = last_time_q;
		comp_len_d  = comp_len_q;
		valid_d     = valid_q;
		frames_d    = frames_q;
		errors_d    = errors_q;
		done_d      = 1'b0;
		rd_ok       = 1'b0;
		we_d        = 1'b0;
		waddr_d     = '0;
		case (item.operation)
			OP_BYTE: begin
				if (brk) begin
					if (receiving_q && slot_q >= min_len_q) begin
						comp_len_d = slot_q;
						valid_d    = 1'b1;
						frames_d   = frames_q + 32'd1;
						done_d     = 1'b1;
					end
					receiving_d = 1'b0;
					slot_d      = '0;
				end
				last_time_d = item.time_us;
				if (!receiving_d) begin
					if (item.byte_value == start_code_q) begin
						receiving_d = 1'b1;
						we_d        = 1'b1;
						waddr_d     = '0;
						slot_d      = SLOT_W'(1);
					end
				end else if (slot_d <= SLOT_W'(MAX_CHANNELS)) begin
					we_d    = 1'b1;
					waddr_d = STORE_AW'(slot_d);
					slot_d  = slot_d + SLOT_W'(1);
				end else begin
					receiving_d = 1'b0;
					slot_d      = '0;
					valid_d     = 1'b0;
					errors_d    = errors_q + 32'd1;
				end
			end
			OP_RX_ERROR: begin
				receiving_d = 1'b0;
				slot_d      = '0;
				valid_d     = 1'b0;
				errors_d    = errors_q + 32'd1;
			end
			OP_READ: begin
				rd_ok = (item.read_channel != '0) &&
					(item.read_channel <= SLOT_W'(MAX_CHANNELS)) &&
					valid_q && (item.read_channel < comp_len_q);
			end
			default: begin
			end
		endcase
	end

	assign store_req.we    = accept & we_d;
	assign store_req.waddr = waddr_d;
	assign store_req.wdata = item.byte_value;
	assign store_req.re    = accept & rd_ok;
	assign store_req.raddr = STORE_AW'(item.read_channel);

	assign status.rd_en        = rd_ok;
	assign status.frame_done   = done_d;
	assign status.frame_length = comp_len_d;
	assign status.frames_total = frames_d;
	assign status.errors_total = errors_d;
	assign status.data_ok      = valid_d;
	assign status.in_frame     = receiving_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			break_gap_q  <= BREAK_GAP_RESET;
			start_code_q <= START_CODE_RESET;
			min_len_q    <= MIN_LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BREAK_GAP:  break_gap_q  <= cfg_data[15:0];
				REG_START_CODE: start_code_q <= cfg_data[7:0];
				REG_MIN_LEN:    min_len_q    <= cfg_data[SLOT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			slot_q      <= '0;
			last_time_q <= '0;
			comp_len_q  <= '0;
			valid_q     <= 1'b0;
			frames_q    <= '0;
			errors_q    <= '0;
		end else if (accept) begin
			receiving_q <= receiving_d;
			slot_q      <= slot_d;
			last_time_q <= last_time_d;
			comp_len_q  <= comp_len_d;
			valid_q     <= valid_d;
			frames_q    <= frames_d;
			errors_q    <= errors_d;
		end
	end

endmodule

// ===== hw/rtl/dmxr_out.sv =====
// read-latency stage and output register with word handshake
module dmxr_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                accept,
	input  dmxr_pkg::status_t   status,
	input  logic [7:0]          rdata,
	output logic                result_valid,
	input  logic                result_stall,
	output dmxr_pkg::out_word_t result
);
	import dmxr_pkg::*;

	logic      valid_s1;
	status_t   stat_s1;
	logic      out_valid_q;
	out_word_t out_q;
	logic      adv;

	assign adv        = valid_s1 & (~out_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~adv;
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stat_s1 <= status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.read_data    <= stat_s1.rd_en ? rdata : 8'd0;
			out_q.frame_done   <= stat_s1.frame_done;
			out_q.frame_length <= stat_s1.frame_length;
			out_q.frames_total <= stat_s1.frames_total;
			out_q.errors_total <= stat_s1.errors_total;
			out_q.data_ok      <= stat_s1.data_ok;
			out_q.in_frame     <= stat_s1.in_frame;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== hw/rtl/dmx_frame_receiver.sv =====
// dmx512 frame receiver top level
// path: an accepted word goes to the read-latency stage, then to the output register
// throughput: one word per cycle while the output is not stalled; each accepted word
// does at most one store access; its read data then goes to the output register
// reset: arst_n clears frame state, counters and handshake state, registers take
// their defaults; the channel store is not cleared and needs no clearing pass
module dmx_frame_receiver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  dmxr_pkg::in_word_t             item,
	output logic                           result_valid,
	input  logic                           result_stall,
	output dmxr_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [dmxr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dmxr_pkg::CFG_W-1:0]     cfg_data
);
	import dmxr_pkg::*;

	logic       accept;
	status_t    status;
	store_req_t store_req;
	logic [7:0] rdata;

	dmxr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.status    (status),
		.store_req (store_req)
	);

	dmxr_store u_store (
		.clk   (clk),
		.req   (store_req),
		.rdata (rdata)
	);

	dmxr_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.accept       (accept),
		.status       (status),
		.rdata        (rdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
